// ===== hdl/sdd_pkg.sv =====
`default_nettype none
package sdd_pkg;

    localparam int unsigned HISTORY_DEPTH_DEF = 128;
    localparam int unsigned SAMPLE_BITS_DEF   = 10;
    localparam int unsigned SLOPE_BITS        = 18;
    localparam int unsigned FALL_BITS         = 19;
    localparam int unsigned FRAC_BITS         = 8;
    localparam int unsigned CFG_ADDR_BITS     = 2;
    localparam int unsigned CFG_DATA_BITS     = 19;
    localparam logic [SLOPE_BITS-1:0] SLOPE_MAX = 18'h3FFFF;

    localparam logic [15:0] DEBOUNCE_RESET  = 16'd500;
    localparam logic [18:0] THRESHOLD_RESET = 19'd3840;
    localparam logic [6:0]  MIN_SPAN_RESET  = 7'd40;
    localparam logic [6:0]  DEPTH_RESET     = 7'd99;
    localparam logic [6:0]  DROP_RESET      = 7'd100;

    typedef enum logic [1:0] {
        OP_DETECT   = 2'd0,
        OP_BASELINE = 2'd1,
        OP_TRIGGER  = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_MIN_SPAN  = 2'd2,
        REG_DEPTH     = 2'd3
    } t_reg;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  sample;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic        fired;
        logic [6:0]  drop_percent;
        logic [6:0]  span_time;
        logic [9:0]  peak_sample;
        logic [17:0] rise_slope;
        logic [18:0] fall_slope;
    } t_out_item;

    // request to the shared divider / status back
    typedef struct packed {
        logic        start;
        logic [25:0] dividend;
        logic [9:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [25:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== hdl/sdd_ram.sv =====
`default_nettype none
module sdd_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/sdd_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle
module sdd_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sdd_pkg::t_div_req i_req,
    output sdd_pkg::t_div_rsp      o_rsp
);
    localparam int unsigned NB = 26;
    logic [NB-1:0] r_quo;
    logic [10:0]   r_rem;
    logic [9:0]    r_den;
    logic [4:0]    r_cnt;
    logic          r_busy, r_done;
    logic [10:0]   w_trial;
    logic [11:0]   w_sub;

    always_comb begin
        w_trial = {r_rem[9:0], r_quo[NB-1]};
        w_sub   = {1'b0, w_trial} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(NB - 1);
                r_quo  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!w_sub[11]) begin
                    r_rem <= w_sub[10:0];
                    r_quo <= {r_quo[NB-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[NB-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

// ===== hdl/sample_dip_detector.sv =====
`default_nettype none
// channel  | signals                        | payload
// input    | i_in_valid / o_in_ready        | sdd_pkg::t_in_item
// output   | o_out_valid / i_out_ready      | sdd_pkg::t_out_item
// config   | i_cfg_we, i_cfg_index, i_cfg_data | 19-bit data, write only
//
// Baseline, trigger, clear and non-scanning detect items go from idle through S_OUT
// into the output register. A detect item that scans reads the history RAM one
// entry a cycle, then evaluates and runs the shared 26-bit divider for the fall
// and rise slopes and, when the dip is kept, the drop percent. Reset clears the
// history RAM in one pass before the first item is taken.
// A stalled result holds in the output register; the next item waits until it
// is taken.
module sample_dip_detector #(
    parameter int unsigned HISTORY_DEPTH = sdd_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire sdd_pkg::t_in_item                 i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output sdd_pkg::t_out_item                     o_out_item,
    input  wire logic                              i_cfg_we,
    input  wire logic [sdd_pkg::CFG_ADDR_BITS-1:0] i_cfg_index,
    input  wire logic [sdd_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_EVAL  = 9'b000001000,
        S_FALL  = 9'b000010000,
        S_RISE  = 9'b000100000,
        S_PCT   = 9'b001000000,
        S_KEEP  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;
    logic [15:0] r_debounce;
    logic [18:0] r_threshold;
    logic [6:0]  r_min_span, r_depth;
    logic [AW-1:0] r_widx, r_raddr;
    logic [9:0]  r_prev, r_cur, r_min;
    logic [CW-1:0] r_i, r_min_dist, r_found, r_lim;
    logic          r_rd_valid;
    logic [6:0]  r_drop, r_span;
    logic [9:0]  r_peak;
    logic [17:0] r_rise, r_new_rise;
    logic [18:0] r_fall;
    logic [17:0] r_new_fall;
    logic [31:0] r_mark;
    logic        r_out_valid;
    sdd_pkg::t_out_item r_out;
    logic        r_div_go;

    logic        w_we;
    logic [AW-1:0] w_waddr;
    logic [9:0]  w_wdata, w_rdata;
    sdd_pkg::t_div_req w_req;
    sdd_pkg::t_div_rsp w_rsp;
    logic [17:0] w_sat;
    logic [CW-1:0] w_fd;
    logic [19:0] w_gap;

    sdd_ram #(.WIDTH(10), .DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(r_raddr), .o_rdata(w_rdata)
    );

    sdd_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    wire w_acc = i_in_valid && o_in_ready;
    wire sdd_pkg::t_op w_op = sdd_pkg::t_op'(i_in_item.op);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_widx;
        w_wdata = i_in_item.sample;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_wdata = '0;
        end else if (w_acc && (w_op == sdd_pkg::OP_DETECT || w_op == sdd_pkg::OP_BASELINE)) begin
            w_we = 1'b1;
        end
    end

    assign w_sat = (|w_rsp.quotient[25:18]) ? sdd_pkg::SLOPE_MAX : w_rsp.quotient[17:0];
    assign w_fd  = r_found - r_min_dist;
    assign w_gap = {2'b00, r_rise} - {r_fall[18], r_fall};

    always_comb begin
        w_req.start    = r_div_go;
        w_req.dividend = {8'd0, r_cur - r_min, 8'd0};
        w_req.divisor  = 10'(w_fd);
        if (r_state == S_RISE) begin
            w_req.divisor = 10'(r_min_dist);
        end else if (r_state == S_PCT) begin
            // minimum * 100 as 64 + 32 + 4
            w_req.dividend = {10'd0, r_min, 6'd0} + {11'd0, r_min, 5'd0}
                           + {14'd0, r_min, 2'd0};
            w_req.divisor  = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_debounce  <= sdd_pkg::DEBOUNCE_RESET;
            r_threshold <= sdd_pkg::THRESHOLD_RESET;
            r_min_span  <= sdd_pkg::MIN_SPAN_RESET;
            r_depth     <= sdd_pkg::DEPTH_RESET;
            r_widx      <= '0;
            r_prev      <= '0;
            r_drop      <= sdd_pkg::DROP_RESET;
            r_span      <= '0;
            r_peak      <= '0;
            r_rise      <= '0;
            r_fall      <= '0;
            r_mark      <= '0;
            r_out_valid <= 1'b0;
            r_div_go    <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (i_cfg_we) begin
                unique case (sdd_pkg::t_reg'(i_cfg_index))
                    sdd_pkg::REG_DEBOUNCE:  r_debounce  <= i_cfg_data[15:0];
                    sdd_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data;
                    sdd_pkg::REG_MIN_SPAN:  r_min_span  <= i_cfg_data[6:0];
                    sdd_pkg::REG_DEPTH:     r_depth     <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_widx <= r_widx + 1'b1;
                    if (r_widx == AW'(HISTORY_DEPTH - 1)) begin
                        r_widx  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_out.fired <= 1'b0;
                        r_cur       <= i_in_item.sample;
                        r_min       <= i_in_item.sample;
                        r_min_dist  <= '0;
                        r_found     <= '0;
                        r_i         <= CW'(1);
                        r_rd_valid  <= 1'b0;
                        r_raddr     <= (r_widx == '0) ? AW'(HISTORY_DEPTH - 1)
                                                      : r_widx - 1'b1;
                        r_lim <= (CW'(r_depth) > CW'(HISTORY_DEPTH - 1))
                               ? CW'(HISTORY_DEPTH - 1) : CW'(r_depth);
                        r_state <= S_OUT;
                        unique case (w_op) inside
                            sdd_pkg::OP_DETECT, sdd_pkg::OP_BASELINE: begin
                                r_prev <= i_in_item.sample;
                                r_widx <= (r_widx == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                            : r_widx + 1'b1;
                                if (w_op == sdd_pkg::OP_DETECT
                                        && i_in_item.sample > r_prev
                                        && r_depth != '0) begin
                                    r_state <= S_SCAN;
                                end
                            end
                            sdd_pkg::OP_TRIGGER: begin
                                if (w_gap > {1'b0, r_threshold}) begin
                                    if ((i_in_item.now_ms - r_mark) > {16'd0, r_debounce}) begin
                                        r_mark      <= i_in_item.now_ms;
                                        r_out.fired <= 1'b1;
                                    end else begin
                                        r_drop <= sdd_pkg::DROP_RESET;
                                        r_span <= '0; r_peak <= '0;
                                        r_rise <= '0; r_fall <= '0;
                                    end
                                end
                            end
                            default: begin
                                r_drop <= sdd_pkg::DROP_RESET;
                                r_span <= '0; r_peak <= '0;
                                r_rise <= '0; r_fall <= '0;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // read one entry ahead; r_i names the entry arriving now
                    r_rd_valid <= 1'b1;
                    r_raddr    <= (r_raddr == '0) ? AW'(HISTORY_DEPTH - 1)
                                                  : r_raddr - 1'b1;
                    if (r_rd_valid) begin
                        if (w_rdata == r_cur) begin
                            r_found <= r_i;
                            r_state <= S_EVAL;
                        end else begin
                            if (w_rdata < r_min) begin
                                r_min      <= w_rdata;
                                r_min_dist <= r_i;
                            end
                            r_i <= r_i + 1'b1;
                            if (r_i == r_lim) r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    if (r_found == '0 || r_min == r_cur
                            || r_found < CW'(r_min_span)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_div_go <= 1'b1;
                        r_state  <= S_FALL;
                    end
                end
                S_FALL: begin
                    if (w_rsp.done) begin
                        r_new_fall <= w_sat;
                        r_div_go   <= 1'b1;
                        r_state    <= S_RISE;
                    end
                end
                S_RISE: begin
                    if (w_rsp.done) begin
                        r_new_rise <= w_sat;
                        // keep only a dip steeper on both sides than the one held
                        if ({1'b0, r_new_fall} > (19'd0 - r_fall) && w_sat > r_rise) begin
                            r_div_go <= 1'b1;
                            r_state  <= S_PCT;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_PCT: begin
                    if (w_rsp.done) begin
                        r_drop  <= w_rsp.quotient[6:0];
                        r_span  <= r_found[6:0];
                        r_peak  <= r_cur;
                        r_rise  <= r_new_rise;
                        r_fall  <= 19'd0 - {1'b0, r_new_fall};
                        r_state <= S_KEEP;
                    end
                end
                S_KEEP: r_state <= S_OUT;
                S_OUT: begin
                    r_out.drop_percent <= r_drop;
                    r_out.span_time    <= r_span;
                    r_out.peak_sample  <= r_peak;
                    r_out.rise_slope   <= r_rise;
                    r_out.fall_slope   <= r_fall;
                    r_out_valid        <= 1'b1;
                    r_state            <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE && !r_out_valid))
        else $error("ready outside idle");
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> !w_rsp.busy)
        else $error("divider restarted while busy");
    a_fall_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.fall_slope[18] || o_out_item.fall_slope == '0))
        else $error("fall slope positive");
`endif
endmodule
`default_nettype wire

// ===== verif/tb_sample_dip_detector.sv =====
`timescale 1ns / 1ps
module tb_sample_dip_detector;
    import sdd_pkg::*;

    localparam int RING = 128;
    localparam int STUCK_LIMIT = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    logic      cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    sample_dip_detector i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // dip tracker shadow state
    logic [15:0] debounce_lim = DEBOUNCE_RESET;
    logic [18:0] threshold = THRESHOLD_RESET;
    logic [6:0]  span_min = MIN_SPAN_RESET;
    logic [6:0]  scan_depth = DEPTH_RESET;
    logic [9:0]  ring_mem [RING];
    int          wr_ptr = 0;
    logic [9:0]  last_sample = '0;
    int          hold_drop = 100, hold_span = 0, hold_peak = 0;
    int          hold_rise = 0, hold_fall = 0;
    logic [31:0] last_fire_ms = '0;

    t_in_item  send_q [$];
    t_out_item dip_expect_q [$];
    int        errors = 0;
    int        send_idle_pct = 0, recv_stall_pct = 0;
    int        hold_req = 0;
    logic      in_taken = 1'b0;
    logic [31:0] clock_ms = '0;

    function automatic int slope_mag(int diff, int den);
        int q;
        if (den == 0) return int'(SLOPE_MAX);
        q = (diff * 256) / den;
        return (q > int'(SLOPE_MAX)) ? int'(SLOPE_MAX) : q;
    endfunction

    function automatic void clear_dip();
        hold_drop = 100; hold_span = 0; hold_peak = 0; hold_rise = 0; hold_fall = 0;
    endfunction

    function automatic void scan_for_dip(int cur, int w);
        int depth, mn, mn_dist, found, v, rise, fall;
        depth = (scan_depth > RING - 1) ? RING - 1 : int'(scan_depth);
        mn = cur; mn_dist = 0; found = 0;
        for (int i = 1; i <= depth; i++) begin
            v = ring_mem[(w + RING - i) % RING];
            if (v == cur) begin
                found = i;
                break;
            end
            if (v < mn) begin
                mn = v;
                mn_dist = i;
            end
        end
        if (found == 0 || mn == cur || found < span_min) return;
        fall = -slope_mag(cur - mn, found - mn_dist);
        rise = slope_mag(cur - mn, mn_dist);
        if (fall < hold_fall && rise > hold_rise) begin
            hold_drop = (mn * 100) / cur;
            hold_span = found;
            hold_peak = cur;
            hold_fall = fall;
            hold_rise = rise;
        end
    endfunction

    function automatic t_out_item predict_dip(t_in_item it);
        t_out_item r;
        logic fired;
        int w;
        fired = 1'b0;
        w = wr_ptr;
        case (it.op)
            OP_DETECT, OP_BASELINE: begin
                ring_mem[w] = it.sample;
                if (it.op == OP_DETECT && it.sample > last_sample)
                    scan_for_dip(it.sample, w);
                last_sample = it.sample;
                wr_ptr = (w + 1) % RING;
            end
            OP_TRIGGER: begin
                if (hold_rise - hold_fall > int'(threshold)) begin
                    if (it.now_ms - last_fire_ms > {16'd0, debounce_lim}) begin
                        last_fire_ms = it.now_ms;
                        fired = 1'b1;
                    end else begin
                        clear_dip();
                    end
                end
            end
            default: clear_dip();
        endcase
        r.fired = fired;
        r.drop_percent = hold_drop[6:0];
        r.span_time = hold_span[6:0];
        r.peak_sample = hold_peak[9:0];
        r.rise_slope = hold_rise[17:0];
        r.fall_slope = hold_fall[18:0];
        return r;
    endfunction

    // driver: hold an item until taken, then maybe idle
    always @(negedge i_clk) begin
        if (!in_valid || in_taken) begin
            if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_item <= send_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver with its own long hold-off counter
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor, predictor hook and watchdog
    int stuck = 0;
    always @(posedge i_clk) begin
        t_out_item exp_r;
        in_taken <= in_valid && in_ready;
        if (in_valid && in_ready)
            dip_expect_q.push_back(predict_dip(in_item));
        if (out_valid && out_ready) begin
            if (dip_expect_q.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
            end else begin
                exp_r = dip_expect_q.pop_front();
                if (out_item.fired !== exp_r.fired) begin
                    $error("fired exp %0d got %0d", exp_r.fired, out_item.fired); errors++;
                end
                if (out_item.drop_percent !== exp_r.drop_percent) begin
                    $error("drop_percent exp %0d got %0d", exp_r.drop_percent,
                           out_item.drop_percent); errors++;
                end
                if (out_item.span_time !== exp_r.span_time) begin
                    $error("span_time exp %0d got %0d", exp_r.span_time,
                           out_item.span_time); errors++;
                end
                if (out_item.peak_sample !== exp_r.peak_sample) begin
                    $error("peak_sample exp %0d got %0d", exp_r.peak_sample,
                           out_item.peak_sample); errors++;
                end
                if (out_item.rise_slope !== exp_r.rise_slope) begin
                    $error("rise_slope exp %0d got %0d", exp_r.rise_slope,
                           out_item.rise_slope); errors++;
                end
                if (out_item.fall_slope !== exp_r.fall_slope) begin
                    $error("fall_slope exp %0h got %0h", exp_r.fall_slope,
                           out_item.fall_slope); errors++;
                end
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (send_q.size() == 0 && !in_valid && dip_expect_q.size() == 0))
            stuck = 0;
        else
            stuck++;
        if (stuck >= STUCK_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(t_reg idx, logic [CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_DEBOUNCE:  debounce_lim = val[15:0];
            REG_THRESHOLD: threshold = val;
            REG_MIN_SPAN:  span_min = val[6:0];
            default:       scan_depth = val[6:0];
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_item(t_op op, int smp, logic [31:0] ms);
        t_in_item it;
        it.op = op;
        it.sample = smp[9:0];
        it.now_ms = ms;
        send_q.push_back(it);
    endtask

    task automatic drain();
        wait (send_q.size() == 0 && !in_valid && dip_expect_q.size() == 0);
        repeat (10) @(negedge i_clk);
    endtask

    // mostly dip shapes (equal, lower run, equal again), plus noise, triggers and clears
    task automatic load_random(int n);
        int cnt, r, v, len, pick;
        cnt = 0;
        while (cnt < n) begin
            r = $urandom_range(99);
            if (r < 55) begin
                v = $urandom_range(1, 1023);
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 130)
                                               : $urandom_range(1, 12);
                push_item($urandom_range(1) ? OP_BASELINE : OP_DETECT, v, 0);
                for (int k = 1; k < len; k++) begin
                    pick = $urandom_range(v - 1);
                    push_item($urandom_range(3) == 0 ? OP_BASELINE : OP_DETECT, pick, 0);
                end
                push_item(OP_DETECT, v, 0);
                cnt += len + 1;
            end else if (r < 80) begin
                if ($urandom_range(7) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms += $urandom_range(0, 2 * debounce_lim + 2);
                push_item(OP_TRIGGER, $urandom_range(1023), clock_ms);
                cnt++;
            end else if (r < 85) begin
                push_item(OP_CLEAR, $urandom_range(1023), $urandom);
                cnt++;
            end else begin
                push_item($urandom_range(1) ? OP_DETECT : OP_BASELINE,
                          $urandom_range(1023), $urandom);
                cnt++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: short dips, nearest-equal stop, extremes, every op
        write_reg(REG_MIN_SPAN, 2);
        write_reg(REG_DEPTH, 127);
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_DEBOUNCE, 0);
        push_item(OP_BASELINE, 1023, 0);
        push_item(OP_DETECT, 0, 0);
        push_item(OP_DETECT, 1023, 0);
        push_item(OP_TRIGGER, 0, 32'd1);
        push_item(OP_TRIGGER, 0, 32'd1);
        push_item(OP_BASELINE, 500, 0);
        push_item(OP_BASELINE, 100, 0);
        push_item(OP_BASELINE, 500, 0);
        push_item(OP_BASELINE, 300, 0);
        push_item(OP_DETECT, 500, 0);
        push_item(OP_TRIGGER, 1023, 32'hFFFF_FFFF);
        push_item(OP_DETECT, 1, 0);
        push_item(OP_DETECT, 0, 0);
        push_item(OP_DETECT, 1, 0);
        push_item(OP_CLEAR, 0, 0);
        push_item(OP_DETECT, 1023, 32'hFFFF_FFFF);
        push_item(OP_TRIGGER, 0, 32'h0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_DEBOUNCE, 0);   write_reg(REG_THRESHOLD, 0);
                    write_reg(REG_MIN_SPAN, 1);   write_reg(REG_DEPTH, 1);
                end
                1: begin
                    write_reg(REG_DEBOUNCE, 65535); write_reg(REG_THRESHOLD, 524287);
                    write_reg(REG_MIN_SPAN, 127);   write_reg(REG_DEPTH, 127);
                end
                2: begin
                    write_reg(REG_DEBOUNCE, 20);  write_reg(REG_THRESHOLD, 3840);
                    write_reg(REG_MIN_SPAN, 3);   write_reg(REG_DEPTH, 127);
                end
                3: begin
                    write_reg(REG_DEBOUNCE, DEBOUNCE_RESET);
                    write_reg(REG_THRESHOLD, $urandom_range(100000));
                    write_reg(REG_MIN_SPAN, 1);   write_reg(REG_DEPTH, 40);
                end
                4: begin
                    write_reg(REG_DEBOUNCE, $urandom_range(65535));
                    write_reg(REG_THRESHOLD, $urandom_range(524287));
                    write_reg(REG_MIN_SPAN, $urandom_range(1, 127));
                    write_reg(REG_DEPTH, $urandom_range(1, 127));
                end
                default: begin
                    write_reg(REG_DEBOUNCE, 5);   write_reg(REG_THRESHOLD, 200);
                    write_reg(REG_MIN_SPAN, 2);   write_reg(REG_DEPTH, 100);
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            if (ph == 2)
                hold_req = 600;
            load_random(165);
            // pause the sender until every result is back
            drain();
            load_random(165);
            drain();
        end

        repeat (300) @(negedge i_clk);
        if (errors == 0 && dip_expect_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
